FILE: rtl/core/kcrp_pkg.sv
// kcrp_pkg: shared sizes, operation and mode codes, and the result record
// for the key change recorder/player. No dependencies.
`default_nettype none

package kcrp_pkg;

    // sizing
    localparam int EVENT_DEPTH = 1024;
    localparam int KEY_COUNT   = 8;
    localparam int KEY_W       = 8;
    localparam int TIME_W      = 32;
    localparam int HELD_W      = 11;
    localparam int COUNT_W     = $clog2(EVENT_DEPTH + 1);
    localparam int ADDR_W      = $clog2(EVENT_DEPTH);
    localparam int ENTRY_W     = TIME_W + KEY_W;

    // keys beyond KEY_COUNT are ignored
    localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_COUNT) - 64'd1);

    // operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_REC   = 2'd1,
        OP_PLAY  = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    // reported mode codes
    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_REC  = 2'd1;
    localparam logic [1:0] MODE_CODE_PLAY = 2'd2;

    // operating mode
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_RECORD = 3'b010,
        MODE_PLAYBACK = 3'b100
    } mode_t;

    // one result transaction
    typedef struct packed {
        logic              event_stored;
        logic              store_full;
        logic [KEY_W-1:0]  press_mask;
        logic [KEY_W-1:0]  release_mask;
        logic [KEY_W-1:0]  current_keys;
        logic [TIME_W-1:0] tick_time;
        logic [HELD_W-1:0] events_held;
        logic [1:0]        mode_now;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/kcrp_in_if.sv
// kcrp_in_if: input channel (valid/ready plus operation and key sample).
// Depends on kcrp_pkg.
`default_nettype none

interface kcrp_in_if;
    import kcrp_pkg::*;

    logic             valid;
    logic             ready;
    op_t              op;
    logic [KEY_W-1:0] key_sample;

    modport source (output valid, output op, output key_sample, input ready);
    modport sink   (input valid, input op, input key_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kcrp_out_if.sv
// kcrp_out_if: result channel (valid/ready plus result fields).
// Depends on kcrp_pkg.
`default_nettype none

interface kcrp_out_if;
    import kcrp_pkg::*;

    logic              valid;
    logic              ready;
    logic              event_stored;
    logic              store_full;
    logic [KEY_W-1:0]  press_mask;
    logic [KEY_W-1:0]  release_mask;
    logic [KEY_W-1:0]  current_keys;
    logic [TIME_W-1:0] tick_time;
    logic [HELD_W-1:0] events_held;
    logic [1:0]        mode_now;

    modport source (
        output valid, input ready,
        output event_stored, output store_full, output press_mask, output release_mask,
        output current_keys, output tick_time, output events_held, output mode_now
    );
    modport sink (
        input valid, output ready,
        input event_stored, input store_full, input press_mask, input release_mask,
        input current_keys, input tick_time, input events_held, input mode_now
    );
endinterface

`default_nettype wire

FILE: rtl/core/kcrp_ram.sv
// kcrp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kcrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/kcrp_core.sv
// kcrp_core: mode, tick counter, key state, event count and play index, plus
// the per-transaction record/playback logic. Depends on kcrp_pkg; drives kcrp_ram.
`default_nettype none

module kcrp_core (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire kcrp_pkg::op_t            op,
    input  wire logic [kcrp_pkg::KEY_W-1:0] key_sample,
    output kcrp_pkg::result_t             result,
    output logic                          ram_we,
    output logic [kcrp_pkg::ADDR_W-1:0]   ram_waddr,
    output logic [kcrp_pkg::ENTRY_W-1:0]  ram_wdata,
    output logic [kcrp_pkg::ADDR_W-1:0]   ram_raddr,
    input  wire logic [kcrp_pkg::ENTRY_W-1:0] ram_rdata
);
    import kcrp_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [TIME_W-1:0]  tick_reg, tick_next;
    logic [KEY_W-1:0]   keys_reg, keys_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] index_reg, index_next;

    logic [KEY_W-1:0]   sample;
    logic [TIME_W-1:0]  ev_time;
    logic [KEY_W-1:0]   ev_keys;
    logic [KEY_W-1:0]   changed;
    logic               stored;
    logic               full;
    logic [KEY_W-1:0]   press;
    logic [KEY_W-1:0]   release_keys;

    // ram read data always holds the entry at the current play index
    assign sample  = key_sample & KEY_MASK;
    assign ev_time = ram_rdata[ENTRY_W-1:KEY_W];
    assign ev_keys = ram_rdata[KEY_W-1:0];
    assign changed = keys_reg ^ ev_keys;

    // next state for one transaction
    always_comb
    begin
        mode_next    = mode_reg;
        tick_next    = tick_reg;
        keys_next    = keys_reg;
        count_next   = count_reg;
        index_next   = index_reg;
        stored       = 1'b0;
        full         = 1'b0;
        press        = '0;
        release_keys = '0;
        ram_we       = 1'b0;
        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    if (mode_reg == MODE_RECORD)
                    begin
                        if (sample != keys_reg || tick_reg == '0)
                        begin
                            if (count_reg < COUNT_W'(EVENT_DEPTH))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                stored     = 1'b1;
                            end
                            else
                            begin
                                full = 1'b1;
                            end
                            keys_next = sample;
                        end
                        tick_next = tick_reg + 1'b1;
                    end
                    else if (mode_reg == MODE_PLAYBACK)
                    begin
                        if (index_reg < count_reg && index_reg < COUNT_W'(EVENT_DEPTH))
                        begin
                            if (tick_reg == ev_time)
                            begin
                                press        = changed & ev_keys;
                                release_keys = changed & ~ev_keys;
                                keys_next    = ev_keys;
                                index_next   = index_reg + 1'b1;
                            end
                            tick_next = tick_reg + 1'b1;
                        end
                    end
                end
                OP_REC:
                begin
                    count_next = '0;
                    tick_next  = '0;
                    keys_next  = '0;
                    mode_next  = MODE_RECORD;
                end
                OP_PLAY:
                begin
                    index_next = '0;
                    tick_next  = '0;
                    mode_next  = MODE_PLAYBACK;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // store port: append at the event count, prefetch at the next play index
    assign ram_waddr = count_reg[ADDR_W-1:0];
    assign ram_wdata = {tick_reg, sample};
    assign ram_raddr = index_next[ADDR_W-1:0];

    // result fields
    always_comb
    begin
        result.event_stored = stored;
        result.store_full   = full;
        result.press_mask   = press;
        result.release_mask = release_keys;
        result.current_keys = keys_next;
        result.tick_time    = tick_next;
        result.events_held  = HELD_W'(count_next);
        case (mode_next)
            MODE_RECORD:   result.mode_now = MODE_CODE_REC;
            MODE_PLAYBACK: result.mode_now = MODE_CODE_PLAY;
            default:       result.mode_now = MODE_CODE_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            tick_reg  <= '0;
            keys_reg  <= '0;
            count_reg <= '0;
            index_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            tick_reg  <= tick_next;
            keys_reg  <= keys_next;
            count_reg <= count_next;
            index_reg <= index_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/kcrp_out_buf.sv
// kcrp_out_buf: two-entry output stage (result register plus skid register)
// that drives the result channel. Depends on kcrp_pkg and kcrp_out_if.
`default_nettype none

module kcrp_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire kcrp_pkg::result_t data,
    output logic                   ready,
    kcrp_out_if.source             result
);
    import kcrp_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign ready = !skid_valid_reg;
    assign pop   = main_valid_reg && result.ready;

    // buffer control
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // drive the result channel
    assign result.valid        = main_valid_reg;
    assign result.event_stored = main_reg.event_stored;
    assign result.store_full   = main_reg.store_full;
    assign result.press_mask   = main_reg.press_mask;
    assign result.release_mask = main_reg.release_mask;
    assign result.current_keys = main_reg.current_keys;
    assign result.tick_time    = main_reg.tick_time;
    assign result.events_held  = main_reg.events_held;
    assign result.mode_now     = main_reg.mode_now;

endmodule

`default_nettype wire

FILE: rtl/core/key_change_recorder_player_unit.sv
// key_change_recorder_player_unit: top level of the key change recorder/player.
// Depends on kcrp_pkg, kcrp_in_if, kcrp_out_if, kcrp_ram, kcrp_core, kcrp_out_buf.
//
// Takes one transaction per clock (tick, start recording, start playing, stop)
// and returns exactly one result transaction per input, registered in the output
// stage. The throughput is one transaction per cycle; the figure is set by
// the single store port: each recording tick writes at most one event, and the
// event at the play index is prefetched from the registered read port so a
// playback tick compares against it in the same cycle. The result leaves
// through a two-entry output stage, so input keeps flowing while one result
// waits; input stalls only when both entries are full. The event store
// (1024 x 40 bits) needs no clearing after reset: playback reads only entries
// that recording has written.
`default_nettype none

module key_change_recorder_player_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kcrp_in_if.sink    item,
    kcrp_out_if.source result
);
    import kcrp_pkg::*;

    logic              accept;
    logic              buf_ready;
    result_t           core_result;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // input handshake
    assign item.ready = buf_ready;
    assign accept     = item.valid && buf_ready;

    kcrp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (item.op),
        .key_sample (item.key_sample),
        .result     (core_result),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    kcrp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (EVENT_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kcrp_out_buf u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .data   (core_result),
        .ready  (buf_ready),
        .result (result)
    );

endmodule

`default_nettype wire

FILE: test/key_change_recorder_player_checker.sv
// key_change_recorder_player_checker: watches both channels of the key change
// recorder/player, predicts each result transaction and compares it field by field.
// Depends on kcrp_pkg, kcrp_in_if and kcrp_out_if.
`default_nettype none

module key_change_recorder_player_checker
    import kcrp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    kcrp_in_if        item,
    kcrp_out_if       result,
    output int        mismatches,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted state of the recorder/player
    logic [1:0]         play_mode;
    logic [TIME_W-1:0]  frame_clock;
    logic [KEY_W-1:0]   held_keys;
    logic [COUNT_W-1:0] recorded_count;
    logic [COUNT_W-1:0] replay_pos;
    logic [TIME_W-1:0]  event_time [EVENT_DEPTH];
    logic [KEY_W-1:0]   event_keys [EVENT_DEPTH];

    // results still owed by the block, oldest first
    result_t owed_results[$];

    // apply one operation to the predicted state and return its result
    function automatic result_t next_key_result(op_t code, logic [KEY_W-1:0] sample);
        result_t          r;
        logic [KEY_W-1:0] keys;
        logic [KEY_W-1:0] upcoming;
        logic [KEY_W-1:0] changed;
        r = '0;
        keys = sample & KEY_MASK;
        case (code)
            OP_TICK:
            begin
                if (play_mode == MODE_CODE_REC)
                begin
                    // store on a key change, and always at time zero
                    if (keys != held_keys || frame_clock == '0)
                    begin
                        if (recorded_count < COUNT_W'(EVENT_DEPTH))
                        begin
                            event_time[recorded_count[ADDR_W-1:0]] = frame_clock;
                            event_keys[recorded_count[ADDR_W-1:0]] = keys;
                            recorded_count = recorded_count + 1'b1;
                            r.event_stored = 1'b1;
                        end
                        else
                        begin
                            r.store_full = 1'b1;
                        end
                        held_keys = keys;
                    end
                    frame_clock = frame_clock + 1'b1;
                end
                else if (play_mode == MODE_CODE_PLAY)
                begin
                    // time stands still once the events run out
                    if (replay_pos < recorded_count)
                    begin
                        if (frame_clock == event_time[replay_pos[ADDR_W-1:0]])
                        begin
                            upcoming = event_keys[replay_pos[ADDR_W-1:0]];
                            changed = held_keys ^ upcoming;
                            r.press_mask = changed & upcoming;
                            r.release_mask = changed & ~upcoming;
                            held_keys = upcoming;
                            replay_pos = replay_pos + 1'b1;
                        end
                        frame_clock = frame_clock + 1'b1;
                    end
                end
            end
            OP_REC:
            begin
                recorded_count = '0;
                frame_clock = '0;
                held_keys = '0;
                play_mode = MODE_CODE_REC;
            end
            OP_PLAY:
            begin
                replay_pos = '0;
                frame_clock = '0;
                play_mode = MODE_CODE_PLAY;
            end
            default:
            begin
                play_mode = MODE_CODE_IDLE;
            end
        endcase
        r.current_keys = held_keys;
        r.tick_time = frame_clock;
        r.events_held = HELD_W'(recorded_count);
        r.mode_now = play_mode;
        return r;
    endfunction

    // one field against its expectation
    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            mismatches++;
        end
    endtask

    // predict on each accepted input, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            play_mode = MODE_CODE_IDLE;
            frame_clock = '0;
            held_keys = '0;
            recorded_count = '0;
            replay_pos = '0;
            owed_results.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (item.valid && item.ready)
                owed_results.push_back(next_key_result(item.op, item.key_sample));
            if (result.valid && result.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result: transaction with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("event_stored", 32'(want.event_stored),
                                32'(result.event_stored));
                    check_field("store_full", 32'(want.store_full), 32'(result.store_full));
                    check_field("press_mask", 32'(want.press_mask), 32'(result.press_mask));
                    check_field("release_mask", 32'(want.release_mask),
                                32'(result.release_mask));
                    check_field("current_keys", 32'(want.current_keys),
                                32'(result.current_keys));
                    check_field("tick_time", want.tick_time, result.tick_time);
                    check_field("events_held", 32'(want.events_held),
                                32'(result.events_held));
                    check_field("mode_now", 32'(want.mode_now), 32'(result.mode_now));
                end
            end
            pending <= owed_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: test/key_change_recorder_player_unit_tb.sv
// key_change_recorder_player_unit_tb: drives recording and playback sessions into
// the key change recorder/player with random gaps and stalls; the checker judges results.
// Depends on kcrp_pkg, kcrp_in_if, kcrp_out_if, the block and its checker.
`default_nettype none

module key_change_recorder_player_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kcrp_pkg::*;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   items_sent;
    bit   calm;

    kcrp_in_if  item_ch ();
    kcrp_out_if result_ch ();

    key_change_recorder_player_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    key_change_recorder_player_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard limit on the run
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // send one transaction after a random gap
    task automatic send_op(op_t code, logic [KEY_W-1:0] keys);
        int gap;
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.op <= code;
        item_ch.key_sample <= keys;
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
    endtask

    // record a short take, then replay it for some ticks
    task automatic short_session();
        int               takes;
        int               replays;
        logic [KEY_W-1:0] keys;
        takes = $urandom_range(1, 30);
        keys = KEY_W'($urandom());
        send_op(OP_REC, KEY_W'($urandom()));
        repeat (takes)
        begin
            case ($urandom_range(0, 3))
                0: keys = KEY_W'($urandom());
                1: keys = keys ^ KEY_W'(1 << $urandom_range(0, KEY_W - 1));
                default: ;
            endcase
            send_op(OP_TICK, keys);
        end
        if ($urandom_range(0, 3) == 0)
            send_op(OP_STOP, KEY_W'($urandom()));
        send_op(OP_PLAY, KEY_W'($urandom()));
        replays = $urandom_range(1, takes + 6);
        repeat (replays) send_op(OP_TICK, KEY_W'($urandom()));
        if ($urandom_range(0, 1) == 0)
            send_op(OP_STOP, KEY_W'($urandom()));
    endtask

    // result side: random stall before each result
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        result_ch.ready <= 1'b1;
        forever
        begin
            do @(posedge clk); while (!result_ch.valid);
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [KEY_W-1:0] keys;
        item_ch.valid = 1'b0;
        item_ch.op = OP_TICK;
        item_ch.key_sample = '0;
        items_sent = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick and stop while idle
        send_op(OP_TICK, 8'hFF);
        send_op(OP_STOP, 8'h00);
        // recording: forced event at time zero, repeats, extremes
        send_op(OP_REC, 8'h00);
        send_op(OP_TICK, 8'h00);
        send_op(OP_TICK, 8'h00);
        send_op(OP_TICK, 8'hFF);
        send_op(OP_TICK, 8'hFF);
        send_op(OP_TICK, 8'h00);
        send_op(OP_TICK, 8'hA5);
        send_op(OP_TICK, 8'h5A);
        // playback taking over recording, held keys kept, runs past the last event
        send_op(OP_PLAY, 8'hFF);
        repeat (8) send_op(OP_TICK, 8'hFF);
        // recording taking over playback, stop while recording
        send_op(OP_REC, 8'hFF);
        send_op(OP_TICK, 8'h3C);
        send_op(OP_STOP, 8'hC3);
        send_op(OP_TICK, 8'h81);
        send_op(OP_PLAY, 8'h00);
        send_op(OP_TICK, 8'h7E);

        // short sessions mixed with stray operations
        while (items_sent < 790)
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 6))
                    send_op(op_t'($urandom_range(0, 3)), KEY_W'($urandom()));
            else
                short_session();
        end

        // fill the store past its depth, then replay the start of it
        send_op(OP_REC, KEY_W'($urandom()));
        keys = '0;
        repeat (EVENT_DEPTH + 4)
        begin
            keys = keys ^ KEY_W'($urandom_range(1, (1 << KEY_W) - 1));
            send_op(OP_TICK, keys);
        end
        send_op(OP_PLAY, KEY_W'($urandom()));
        repeat (150) send_op(OP_TICK, KEY_W'($urandom()));
        send_op(OP_STOP, KEY_W'($urandom()));
        item_ch.valid <= 1'b0;

        // drain the outstanding results
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
